@@ hdl/u64dec_pkg.sv @@
// Package for the 64-bit to decimal ASCII converter: word types, constants and helpers.
package u64dec_pkg;

    // Field widths of the input and result words.
    localparam int VALUE_W  = 64;
    localparam int SIZE_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 5;
    localparam int DIGIT_W  = 4;

    // Digit chain: one cell per decimal digit, several value bits per cycle.
    localparam int NUM_CELLS     = 20;
    localparam int BITS_PER_STEP = 8;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(CONV_STEPS);

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

    // Input word.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [SIZE_W-1:0]  buffer_size;
    } t_in;

    // Result word.
    typedef struct packed {
        logic              fits;
        logic [BYTE_W-1:0] text_byte;
        logic [POS_W-1:0]  position;
        logic              last;
    } t_out;

    // Controls shared by every cell of the chain.
    typedef struct packed {
        logic load;
        logic conv;
        logic shift;
    } t_cell_ctrl;

    // Digit count from the per-digit nonzero flags; zero still has one digit.
    function automatic logic [POS_W-1:0] f_width(input logic [NUM_CELLS-1:0] nz);
        logic [POS_W-1:0] w;
        w = POS_W'(1);
        for (int c = 0; c < NUM_CELLS; c++) begin
            if (nz[c]) begin
                w = POS_W'(c + 1);
            end
        end
        return w;
    endfunction

endpackage

@@ hdl/u64dec_cell.sv @@
// One BCD digit cell of the shift-and-add-3 chain, with a digit shift path for readout.
module u64dec_cell (
    input  logic                                    i_clk,
    input  u64dec_pkg::t_cell_ctrl                  i_ctrl,
    input  logic [u64dec_pkg::BITS_PER_STEP-1:0]    i_bits,
    input  logic [u64dec_pkg::DIGIT_W-1:0]          i_digit,
    output logic [u64dec_pkg::BITS_PER_STEP-1:0]    o_bits,
    output logic [u64dec_pkg::DIGIT_W-1:0]          o_digit
);

    logic [u64dec_pkg::DIGIT_W-1:0] r_digit;
    logic [u64dec_pkg::DIGIT_W-1:0] n_digit;

    // Several double-dabble steps per cycle: correct the digit, pass its top bit
    // up the chain, then take in the bit from the neighbor below. Bit 7 goes first.
    always_comb begin
        logic [u64dec_pkg::DIGIT_W-1:0] v;
        v = r_digit;
        o_bits = '0;
        for (int j = 0; j < u64dec_pkg::BITS_PER_STEP; j++) begin
            if (v >= 4'd5) begin
                v = v + 4'd3;
            end
            o_bits[u64dec_pkg::BITS_PER_STEP-1-j] = v[u64dec_pkg::DIGIT_W-1];
            v = {v[u64dec_pkg::DIGIT_W-2:0], i_bits[u64dec_pkg::BITS_PER_STEP-1-j]};
        end
        n_digit = v;
    end

    // Digit register: cleared on a new word, updated while converting,
    // moved up one place per emitted character.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_digit <= '0;
        end else if (i_ctrl.conv) begin
            r_digit <= n_digit;
        end else if (i_ctrl.shift) begin
            r_digit <= i_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

@@ hdl/uint64_to_decimal_ascii.sv @@
// Top level: converts a 64-bit unsigned value to decimal ASCII text, one character per word.
//
// Usage: drive the input word on i_in and raise start while busy is low; the
// word is taken at that clock edge and busy rises in the next cycle.
// The value shifts into a chain of 20 BCD digit cells, eight bits per cycle; after
// the conversion, the counting state works out how many digits the value has.
// Then the result words appear on o_out, one per cycle, each marked by o_strobe
// for exactly one cycle: the digits most significant first with their buffer
// positions, then a zero terminator marked last. If the digits and terminator
// do not fit the buffer, a single word with fits cleared and last set comes out.
// busy falls in the cycle that shows the last word, so a new start may be taken
// at the edge that ends it. The receiver cannot stall: every word is taken as shown.
// Reset clears the control state and the strobe; busy is low after reset.
module uint64_to_decimal_ascii (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  u64dec_pkg::t_in     i_in,
    output logic                o_strobe,
    output u64dec_pkg::t_out    o_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_COUNT = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                                 r_state;
    logic [u64dec_pkg::VALUE_W-1:0]         r_value;
    logic [u64dec_pkg::SIZE_W-1:0]          r_size;
    logic [u64dec_pkg::CNT_W-1:0]           r_cnt;
    logic [u64dec_pkg::POS_W-1:0]           r_width;
    logic [u64dec_pkg::POS_W-1:0]           r_pos;
    logic                                   r_fail;
    logic                                   r_strobe;
    u64dec_pkg::t_out                       r_out;

    u64dec_pkg::t_cell_ctrl                 w_ctrl;
    logic [u64dec_pkg::BITS_PER_STEP-1:0]   w_bits  [0:u64dec_pkg::NUM_CELLS];
    logic [u64dec_pkg::DIGIT_W-1:0]         w_digit [0:u64dec_pkg::NUM_CELLS];
    logic [u64dec_pkg::NUM_CELLS-1:0]       w_nz;
    logic [u64dec_pkg::POS_W-1:0]           w_width;
    logic [u64dec_pkg::DIGIT_W-1:0]         w_top;
    logic                                   w_accept;
    logic                                   w_more;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_more   = (r_pos != r_width);

    // Chain ends: the value enters at the bottom, zeros fill in during readout.
    assign w_bits[0]  = r_value[u64dec_pkg::VALUE_W-1 -: u64dec_pkg::BITS_PER_STEP];
    assign w_digit[0] = '0;

    assign w_ctrl.load  = w_accept;
    assign w_ctrl.conv  = (r_state == S_CONV);
    assign w_ctrl.shift = (r_state == S_EMIT) && !r_fail && w_more;

    // The row of digit cells, least significant digit at the bottom.
    for (genvar c = 0; c < u64dec_pkg::NUM_CELLS; c++) begin : g_cell
        u64dec_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_bits  (w_bits[c]),
            .i_digit (w_digit[c]),
            .o_bits  (w_bits[c+1]),
            .o_digit (w_digit[c+1])
        );
        assign w_nz[c] = |w_digit[c+1];
    end

    assign w_width = u64dec_pkg::f_width(w_nz);

    // The leading digit sits in cell width-1; the cells move up under it.
    assign w_top = w_digit[r_width];

    // Sequencer: load, convert, count digits, emit characters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (r_cnt == u64dec_pkg::CNT_W'(u64dec_pkg::CONV_STEPS - 1)) begin
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    if (r_fail || !w_more) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: value shifter, step counter, digit count and output word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_in.value;
            r_size  <= i_in.buffer_size;
            r_cnt   <= '0;
        end
        if (r_state == S_CONV) begin
            r_value <= r_value << u64dec_pkg::BITS_PER_STEP;
            r_cnt   <= r_cnt + 1'b1;
        end
        if (r_state == S_COUNT) begin
            r_width <= w_width;
            r_fail  <= ({{(u64dec_pkg::SIZE_W - u64dec_pkg::POS_W){1'b0}}, w_width} >= r_size);
            r_pos   <= '0;
        end
        if (r_state == S_EMIT) begin
            if (r_fail) begin
                r_out.fits      <= 1'b0;
                r_out.text_byte <= '0;
                r_out.position  <= '0;
                r_out.last      <= 1'b1;
            end else if (w_more) begin
                r_out.fits      <= 1'b1;
                r_out.text_byte <= u64dec_pkg::ASCII_ZERO
                                   + {{(u64dec_pkg::BYTE_W - u64dec_pkg::DIGIT_W){1'b0}}, w_top};
                r_out.position  <= r_pos;
                r_out.last      <= 1'b0;
                r_pos           <= r_pos + 1'b1;
            end else begin
                r_out.fits      <= 1'b1;
                r_out.text_byte <= '0;
                r_out.position  <= r_width;
                r_out.last      <= 1'b1;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // Twenty digits always hold a 64-bit value, so nothing carries out of the top cell.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (w_bits[u64dec_pkg::NUM_CELLS] == '0))
        else $error("digit chain overflowed during conversion");

    // A word goes out only after an emit cycle.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EMIT))
        else $error("result strobe without emit cycle");

    // The last word of a run coincides with the block going idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last) |-> !busy)
        else $error("last word shown while still busy");

    // The first character of a multi-digit number is never a leading zero.
    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.fits && !o_out.last && (o_out.position == '0))
        |-> ((o_out.text_byte != u64dec_pkg::ASCII_ZERO) || (r_width == u64dec_pkg::POS_W'(1))))
        else $error("leading zero emitted");

    // A failure is always a single word.
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out.fits) |-> o_out.last)
        else $error("failure word not marked last");

endmodule

@@ verif/uint64_to_decimal_ascii_checker.sv @@
// Checker for the decimal text converter: predicts result words and compares them.
`timescale 1ns / 1ps

module uint64_to_decimal_ascii_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  u64dec_pkg::t_in     i_word,
    input  logic                i_strobe,
    input  u64dec_pkg::t_out    i_result,
    output int                  o_mismatch_count,
    output int                  o_pending_count,
    output int                  o_checked_count
);

    localparam int MAX_DIGITS   = 20;
    localparam int RADIX        = 10;
    localparam int REPORT_LIMIT = 10;

    // Characters still owed by the converter, oldest first.
    u64dec_pkg::t_out owed_chars[$];
    int               mismatches = 0;
    int               checked = 0;

    // Work out the characters that one accepted word produces.
    task automatic predict_text(input u64dec_pkg::t_in w);
        logic [u64dec_pkg::VALUE_W-1:0] rest;
        logic [u64dec_pkg::DIGIT_W-1:0] digit_rev [MAX_DIGITS];
        int                             n_digits;
        u64dec_pkg::t_out               ch;
        rest = w.value;
        n_digits = 0;
        // Zero still counts as one digit.
        while ((n_digits == 0 || rest != 0) && n_digits < MAX_DIGITS) begin
            digit_rev[n_digits] = u64dec_pkg::DIGIT_W'(rest % u64dec_pkg::VALUE_W'(RADIX));
            rest = rest / u64dec_pkg::VALUE_W'(RADIX);
            n_digits++;
        end
        if (u64dec_pkg::SIZE_W'(n_digits) >= w.buffer_size) begin
            // The text and its terminator do not fit: one failure word.
            ch.fits      = 1'b0;
            ch.text_byte = '0;
            ch.position  = '0;
            ch.last      = 1'b1;
            owed_chars.push_back(ch);
        end else begin
            for (int i = 0; i < n_digits; i++) begin
                ch.fits      = 1'b1;
                ch.text_byte = u64dec_pkg::ASCII_ZERO
                               + u64dec_pkg::BYTE_W'(digit_rev[n_digits - 1 - i]);
                ch.position  = u64dec_pkg::POS_W'(i);
                ch.last      = 1'b0;
                owed_chars.push_back(ch);
            end
            ch.fits      = 1'b1;
            ch.text_byte = '0;
            ch.position  = u64dec_pkg::POS_W'(n_digits);
            ch.last      = 1'b1;
            owed_chars.push_back(ch);
        end
    endtask

    // Compare every strobed word with the oldest prediction, then record new input.
    always @(posedge i_clk) begin
        u64dec_pkg::t_out want;
        if (!i_rst_n) begin
            owed_chars.delete();
        end else begin
            if (i_strobe) begin
                checked++;
                if (owed_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected result word: fits=%0b byte=%02h",
                                 $realtime, i_result.fits, i_result.text_byte);
                        $display("    pos=%0d last=%0b",
                                 i_result.position, i_result.last);
                    end
                end else begin
                    want = owed_chars.pop_front();
                    if (i_result.fits !== want.fits ||
                        i_result.text_byte !== want.text_byte ||
                        i_result.position !== want.position ||
                        i_result.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("[%0t] result word mismatch:", $realtime);
                            $display("    expected fits=%0b byte=%02h pos=%0d last=%0b",
                                     want.fits, want.text_byte, want.position,
                                     want.last);
                            $display("    got      fits=%0b byte=%02h pos=%0d last=%0b",
                                     i_result.fits, i_result.text_byte,
                                     i_result.position, i_result.last);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_text(i_word);
            end
        end
        o_mismatch_count <= mismatches;
        o_checked_count  <= checked;
        o_pending_count  <= owed_chars.size();
    end

endmodule

@@ verif/uint64_to_decimal_ascii_tb.sv @@
// Testbench top for the decimal text converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module uint64_to_decimal_ascii_tb;

    localparam int N_RANDOM    = 160;
    localparam int CALM_TAIL   = 30;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 40;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             o_strobe;
    u64dec_pkg::t_in  i_in;
    u64dec_pkg::t_out o_out;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int words_sent = 0;
    int directed_count = 0;
    int cycle_count = 0;
    bit idle_on = 1'b1;

    uint64_to_decimal_ascii dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    uint64_to_decimal_ascii_checker text_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_word           (i_in),
        .i_strobe         (o_strobe),
        .i_result         (o_out),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_checked_count  (checked_count)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding.",
                     cycle_count, pending_count);
            $display("uint64_to_decimal_ascii test failed");
            $finish;
        end
    end

    // Offer one word, optionally after an idle burst, and hold it until taken.
    task automatic send_word(input logic [u64dec_pkg::VALUE_W-1:0] value,
                             input logic [u64dec_pkg::SIZE_W-1:0] size);
        u64dec_pkg::t_in w;
        int              gap;
        w.value = value;
        w.buffer_size = size;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        words_sent++;
    endtask

    // Values spread over all digit counts, with decade edges and full-width patterns.
    function automatic logic [u64dec_pkg::VALUE_W-1:0] random_value();
        logic [u64dec_pkg::VALUE_W-1:0] v;
        int                             k;
        case ($urandom_range(0, 4))
            0: begin
                v = {$urandom, $urandom};
            end
            1: begin
                v = u64dec_pkg::VALUE_W'($urandom_range(0, 999));
            end
            2: begin
                // A power of ten or one below it.
                v = u64dec_pkg::VALUE_W'(1);
                k = $urandom_range(0, 19);
                repeat (k) v = v * 10;
                v = v - u64dec_pkg::VALUE_W'($urandom_range(0, 1));
            end
            3: begin
                v = {$urandom, $urandom} >> $urandom_range(0, 63);
            end
            default: begin
                v = '1 - u64dec_pkg::VALUE_W'($urandom_range(0, 3));
            end
        endcase
        return v;
    endfunction

    // Buffer sizes mostly around the digit counts, sometimes anywhere in range.
    function automatic logic [u64dec_pkg::SIZE_W-1:0] random_size();
        logic [u64dec_pkg::SIZE_W-1:0] s;
        case ($urandom_range(0, 5))
            0: s = u64dec_pkg::SIZE_W'($urandom);
            1: s = u64dec_pkg::SIZE_W'($urandom_range(0, 3));
            2: s = u64dec_pkg::SIZE_W'(21);
            default: s = u64dec_pkg::SIZE_W'($urandom_range(0, 24));
        endcase
        return s;
    endfunction

    // Stimulus and verdict.
    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_in    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: tiny buffers, zero, decade edges, the widest values.
        send_word(64'd0, 16'd0);
        send_word(64'd0, 16'd1);
        send_word(64'd0, 16'd2);
        send_word(64'd9, 16'd2);
        send_word(64'd10, 16'd2);
        send_word(64'd10, 16'd3);
        send_word(64'd99, 16'd3);
        send_word(64'd100, 16'd4);
        send_word(64'd1234567890, 16'd10);
        send_word(64'd1234567890, 16'd11);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 16'd20);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 16'd21);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_word(64'd10000000000000000000, 16'd21);
        send_word(64'd9999999999999999999, 16'd19);
        send_word(64'd9999999999999999999, 16'd20);
        send_word(64'h5555_5555_5555_5555, 16'hAAAA);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
        send_word(64'd1, 16'h8000);
        send_word(64'd7, 16'h7FFF);
        directed_count = words_sent;

        // Random part; the tail runs back to back.
        for (int n = 0; n < N_RANDOM; n++) begin
            idle_on = (n < N_RANDOM - CALM_TAIL);
            send_word(random_value(), random_size());
        end
        start <= 1'b0;

        // Let every owed word arrive, then allow for one full conversion more.
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Converted %0d values (%0d directed, the rest random) and checked %0d words.",
                 words_sent, directed_count, checked_count);
        $display("Mismatches: %0d, words still owed: %0d.", mismatch_count, pending_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("uint64_to_decimal_ascii test passed");
        end else begin
            $display("uint64_to_decimal_ascii test failed");
        end
        $finish;
    end

endmodule
